@@ rtl/itp_pkg.sv @@
// ----------------------------------------------------------------------------
// itp_pkg
// Types, codes and helpers shared by the infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int ENTRY_W     = 6;

	localparam logic [2:0] KIND_NUM   = 3'd0;
	localparam logic [2:0] KIND_OP    = 3'd1;
	localparam logic [2:0] KIND_LPAR  = 3'd2;
	localparam logic [2:0] KIND_RPAR  = 3'd3;
	localparam logic [2:0] KIND_COMMA = 3'd4;
	localparam logic [2:0] KIND_NAME  = 3'd5;
	localparam logic [2:0] KIND_END   = 3'd6;
	localparam logic [2:0] KIND_NONE  = 3'd7;
	localparam logic [2:0] KIND_START = 3'd7;

	localparam logic [2:0] OP_POW = 3'd0;
	localparam logic [2:0] OP_MUL = 3'd1;
	localparam logic [2:0] OP_DIV = 3'd2;
	localparam logic [2:0] OP_MOD = 3'd3;
	localparam logic [2:0] OP_ADD = 3'd4;
	localparam logic [2:0] OP_SUB = 3'd5;

	localparam logic [3:0] NAME_FUNC_LAST = 4'd11;
	localparam logic [3:0] NAME_PI        = 4'd12;
	localparam logic [3:0] NAME_E         = 4'd13;

	localparam logic [1:0] CLS_BIN  = 2'd0;
	localparam logic [1:0] CLS_FUNC = 2'd1;
	localparam logic [1:0] CLS_NEG  = 2'd2;
	localparam logic [1:0] CLS_LPAR = 2'd3;

	localparam logic [1:0] OUT_NUM  = 2'd0;
	localparam logic [1:0] OUT_BIN  = 2'd1;
	localparam logic [1:0] OUT_FUNC = 2'd2;
	localparam logic [1:0] OUT_NEG  = 2'd3;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_NAME     = 3'd1;
	localparam logic [2:0] ERR_COMMA    = 3'd2;
	localparam logic [2:0] ERR_OP       = 3'd3;
	localparam logic [2:0] ERR_PAREN    = 3'd4;
	localparam logic [2:0] ERR_OVERFLOW = 3'd5;

	localparam logic [3:0] PREC_POW = 4'd8;
	localparam logic [3:0] PREC_NEG = 4'd7;
	localparam logic [3:0] PREC_MUL = 4'd6;
	localparam logic [3:0] PREC_ADD = 4'd4;

	localparam logic [63:0] PI_BITS = 64'h400921FB54442D18;
	localparam logic [63:0] E_BITS  = 64'h4005BF0A8B145769;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  op_code;
		logic [3:0]  name_id;
		logic [63:0] number_bits;
	} tok_beat_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [2:0]  out_op;
		logic [3:0]  out_func;
		logic [63:0] out_value;
		logic [2:0]  error_code;
		logic        last;
	} pfx_beat_t;

	typedef struct packed {
		logic [1:0] cls;
		logic [3:0] code;
	} entry_t;

	typedef struct packed {
		logic pop;
		logic is_lpar;
		logic is_func;
	} cmp_res_t;

	function automatic logic [3:0] prec_of(entry_t e);
		logic [3:0] p;
		if (e.cls == CLS_NEG) begin
			p = PREC_NEG;
		end else if (e.code == {1'b0, OP_POW}) begin
			p = PREC_POW;
		end else if (e.code <= {1'b0, OP_MOD}) begin
			p = PREC_MUL;
		end else begin
			p = PREC_ADD;
		end
		return p;
	endfunction

	function automatic pfx_beat_t num_beat(logic [63:0] value);
		pfx_beat_t b;
		b = '0;
		b.out_kind  = OUT_NUM;
		b.out_value = value;
		return b;
	endfunction

	function automatic pfx_beat_t err_beat(logic [2:0] code);
		pfx_beat_t b;
		b = '0;
		b.error_code = code;
		return b;
	endfunction

	function automatic pfx_beat_t entry_beat(entry_t e);
		pfx_beat_t b;
		b = '0;
		case (e.cls)
			CLS_BIN: begin
				b.out_kind = OUT_BIN;
				b.out_op   = e.code[2:0];
			end
			CLS_FUNC: begin
				b.out_kind = OUT_FUNC;
				b.out_func = e.code;
			end
			CLS_NEG: begin
				b.out_kind = OUT_NEG;
			end
			default: begin
				b.out_kind = OUT_NUM;
			end
		endcase
		return b;
	endfunction

endpackage

@@ rtl/itp_ram.sv @@
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/itp_cmp.sv @@
// ----------------------------------------------------------------------------
// itp_cmp
// Precedence compare unit: classifies a stack entry against the incoming
// operator and decides whether it pops.
// ----------------------------------------------------------------------------
module itp_cmp (
	input  logic [2:0]       op,
	input  itp_pkg::entry_t  entry,
	output itp_pkg::cmp_res_t res
);
	import itp_pkg::*;

	entry_t     me;
	logic [3:0] p_new;
	logic [3:0] p_top;
	logic       is_op;

	always_comb begin
		me          = '{cls: CLS_BIN, code: {1'b0, op}};
		p_new       = prec_of(me);
		p_top       = prec_of(entry);
		is_op       = (entry.cls == CLS_BIN) || (entry.cls == CLS_NEG);
		res.is_lpar = (entry.cls == CLS_LPAR);
		res.is_func = (entry.cls == CLS_FUNC);
		res.pop     = is_op && ((op == OP_POW) ? (p_new < p_top) : (p_new <= p_top));
	end

endmodule

@@ rtl/infix_to_postfix_converter_top.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter from tokenized infix items to postfix items.
// Output: every beat is held in a pending register and moves to the output
// at the next emit or at the flush that ends the token.
// Flow: a token is taken only in ST_IDLE, and output stalls can hold it; it passes ST_DISP,
// then ST_READ (RAM read) and ST_EVAL (compare) per entry read back, ST_PUSH or ST_ERR if needed, and ST_FIN.
// Reset: stack empty, start-of-expression marker, no error; stack RAM
// contents are left as they are.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tok_valid,
	output logic                tok_stall,
	input  itp_pkg::tok_beat_t  tok,
	output logic                pfx_valid,
	input  logic                pfx_stall,
	output itp_pkg::pfx_beat_t  pfx
);
	import itp_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DISP = 7'b0000010,
		ST_READ = 7'b0000100,
		ST_EVAL = 7'b0001000,
		ST_PUSH = 7'b0010000,
		ST_ERR  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	logic [2:0]       kind_q;
	logic [2:0]       op_q;
	logic [3:0]       name_q;
	logic [63:0]      num_q;
	logic             ign_q;
	logic             fn_q, fn_d;
	logic [LVL_W-1:0] level_q, level_d;
	logic [LVL_W-1:0] lvl_m1;
	logic             more;
	logic [2:0]       prev_q, prev_d;
	logic             err_q, err_d;
	logic [2:0]       errc_q, errc_d;
	entry_t           push_q, push_d;

	logic             rd_en;
	logic             wr_en;
	logic [ENTRY_W-1:0] rd_data;
	entry_t           top_entry;
	cmp_res_t         cmp;

	logic             emit_req;
	pfx_beat_t        emit_beat;
	logic             emit_go;
	logic             out_free;
	logic             can_emit;
	logic             flush;
	logic             accept;

	logic             out_vld_q;
	pfx_beat_t        out_q;
	logic             pend_vld_q;
	pfx_beat_t        pend_q;
	pfx_beat_t        fin_beat;

	assign tok_stall = (state_q != ST_IDLE);
	assign accept    = tok_valid && !tok_stall;
	assign pfx_valid = out_vld_q;
	assign pfx       = out_q;
	assign out_free  = !out_vld_q || !pfx_stall;
	assign can_emit  = !pend_vld_q || out_free;
	assign emit_go   = emit_req && can_emit;
	assign flush     = (state_q == ST_FIN) && pend_vld_q && out_free;
	assign top_entry = entry_t'(rd_data);
	assign lvl_m1    = level_q - LVL_W'(1);
	assign more      = (lvl_m1 != '0);

	always_comb begin
		fin_beat      = pend_q;
		fin_beat.last = 1'b1;
	end

	itp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(level_q[ADDR_W-1:0]),
		.wr_data(ENTRY_W'(push_q)),
		.rd_en  (rd_en),
		.rd_addr(lvl_m1[ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	itp_cmp u_cmp (
		.op   (op_q),
		.entry(top_entry),
		.res  (cmp)
	);

	always_comb begin
		state_d   = state_q;
		level_d   = level_q;
		prev_d    = prev_q;
		err_d     = err_q;
		errc_d    = errc_q;
		push_d    = push_q;
		fn_d      = fn_q;
		emit_req  = 1'b0;
		emit_beat = '0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					fn_d    = 1'b0;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				if (kind_q == KIND_END) begin
					state_d = (ign_q || level_q == '0) ? ST_FIN : ST_READ;
				end else if (kind_q == KIND_NONE || ign_q) begin
					state_d = ST_FIN;
				end else begin
					case (kind_q)
						KIND_NUM: begin
							emit_req  = 1'b1;
							emit_beat = num_beat(num_q);
							if (can_emit) state_d = ST_FIN;
						end
						KIND_OP: begin
							if (op_q == OP_SUB &&
							    prev_q inside {KIND_START, KIND_OP, KIND_LPAR, KIND_COMMA}) begin
								push_d  = '{cls: CLS_NEG, code: 4'd0};
								state_d = ST_PUSH;
							end else if (op_q > OP_SUB) begin
								errc_d  = ERR_OP;
								state_d = ST_ERR;
							end else begin
								push_d  = '{cls: CLS_BIN, code: {1'b0, op_q}};
								state_d = (level_q != '0) ? ST_READ : ST_PUSH;
							end
						end
						KIND_LPAR: begin
							push_d  = '{cls: CLS_LPAR, code: 4'd0};
							state_d = ST_PUSH;
						end
						KIND_RPAR: begin
							if (level_q != '0) begin
								state_d = ST_READ;
							end else begin
								errc_d  = ERR_PAREN;
								state_d = ST_ERR;
							end
						end
						KIND_COMMA: begin
							if (level_q != '0) begin
								state_d = ST_READ;
							end else begin
								errc_d  = ERR_COMMA;
								state_d = ST_ERR;
							end
						end
						KIND_NAME: begin
							if (name_q <= NAME_FUNC_LAST) begin
								push_d  = '{cls: CLS_FUNC, code: name_q};
								state_d = ST_PUSH;
							end else if (name_q == NAME_PI || name_q == NAME_E) begin
								emit_req  = 1'b1;
								emit_beat = num_beat((name_q == NAME_PI) ? PI_BITS : E_BITS);
								if (can_emit) state_d = ST_FIN;
							end else begin
								errc_d  = ERR_NAME;
								state_d = ST_ERR;
							end
						end
						default: begin
							state_d = ST_FIN;
						end
					endcase
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				case (kind_q)
					KIND_OP: begin
						if (cmp.pop) begin
							emit_req  = 1'b1;
							emit_beat = entry_beat(top_entry);
							if (can_emit) begin
								level_d = lvl_m1;
								state_d = more ? ST_READ : ST_PUSH;
							end
						end else begin
							state_d = ST_PUSH;
						end
					end
					KIND_RPAR: begin
						if (fn_q) begin
							if (cmp.is_func) begin
								emit_req  = 1'b1;
								emit_beat = entry_beat(top_entry);
								if (can_emit) begin
									level_d = lvl_m1;
									state_d = ST_FIN;
								end
							end else begin
								state_d = ST_FIN;
							end
						end else if (cmp.is_lpar) begin
							level_d = lvl_m1;
							fn_d    = more;
							state_d = more ? ST_READ : ST_FIN;
						end else begin
							emit_req  = 1'b1;
							emit_beat = entry_beat(top_entry);
							if (can_emit) begin
								level_d = lvl_m1;
								errc_d  = ERR_PAREN;
								state_d = more ? ST_READ : ST_ERR;
							end
						end
					end
					KIND_COMMA: begin
						if (cmp.is_lpar) begin
							state_d = ST_FIN;
						end else begin
							emit_req  = 1'b1;
							emit_beat = entry_beat(top_entry);
							if (can_emit) begin
								level_d = lvl_m1;
								errc_d  = ERR_COMMA;
								state_d = more ? ST_READ : ST_ERR;
							end
						end
					end
					KIND_END: begin
						if (cmp.is_lpar) begin
							level_d = lvl_m1;
							errc_d  = ERR_PAREN;
							state_d = ST_ERR;
						end else begin
							emit_req  = 1'b1;
							emit_beat = entry_beat(top_entry);
							if (can_emit) begin
								level_d = lvl_m1;
								state_d = more ? ST_READ : ST_FIN;
							end
						end
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end
			ST_PUSH: begin
				if (level_q >= LVL_W'(STACK_DEPTH)) begin
					errc_d  = ERR_OVERFLOW;
					state_d = ST_ERR;
				end else begin
					wr_en   = 1'b1;
					level_d = level_q + LVL_W'(1);
					state_d = ST_FIN;
				end
			end
			ST_ERR: begin
				emit_req  = 1'b1;
				emit_beat = err_beat(errc_q);
				if (can_emit) begin
					err_d   = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (can_emit) begin
					if (kind_q == KIND_END) begin
						level_d = '0;
						prev_d  = KIND_START;
						err_d   = 1'b0;
					end else if (kind_q != KIND_NONE && !ign_q) begin
						prev_d = kind_q;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			level_q    <= '0;
			prev_q     <= KIND_START;
			err_q      <= 1'b0;
			fn_q       <= 1'b0;
			ign_q      <= 1'b0;
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
			prev_q  <= prev_d;
			err_q   <= err_d;
			fn_q    <= fn_d;
			if (accept) begin
				ign_q <= err_q;
			end
			if ((emit_go && pend_vld_q) || flush) begin
				out_vld_q <= 1'b1;
			end else if (!pfx_stall) begin
				out_vld_q <= 1'b0;
			end
			if (emit_go) begin
				pend_vld_q <= 1'b1;
			end else if (flush) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= tok.kind;
			op_q   <= tok.op_code;
			name_q <= tok.name_id;
			num_q  <= tok.number_bits;
		end
		errc_q <= errc_d;
		push_q <= push_d;
		if (emit_go) begin
			pend_q <= emit_beat;
		end
		if (emit_go && pend_vld_q) begin
			out_q <= pend_q;
		end else if (flush) begin
			out_q <= fin_beat;
		end
	end

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(STACK_DEPTH))
		else $error("stack level beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> level_q < LVL_W'(STACK_DEPTH))
		else $error("push into full stack");

	a_idle_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_vld_q)
		else $error("pending beat left behind at idle");

	a_err_beat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pfx_valid && pfx.error_code != ERR_NONE) |->
		(pfx.out_kind == OUT_NUM && pfx.out_value == '0 && pfx.out_op == '0))
		else $error("error beat carries payload");

endmodule
